/* hdl/greedy_iou_box_suppressor_core_assert.svh */
// ---------------------------------------------------------------------------
// greedy_iou_box_suppressor_core assertion macros
// concurrent assertion wrappers, empty under synthesis
// ---------------------------------------------------------------------------
`ifndef GREEDY_IOU_BOX_SUPPRESSOR_CORE_ASSERT_SVH
`define GREEDY_IOU_BOX_SUPPRESSOR_CORE_ASSERT_SVH

`ifndef SYNTHESIS

`define GIBS_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("gibs assertion failed");

`define GIBS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("gibs assertion failed");

`else

`define GIBS_ASSERT(label, clk, rst_n, prop)

`define GIBS_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

/* hdl/gibs_pkg.sv */
// ---------------------------------------------------------------------------
// gibs_pkg
// shared constants and types of the greedy iou box suppressor
// ---------------------------------------------------------------------------
package gibs_pkg;

    localparam int MAX_KEPT     = 64;
    localparam int MAX_SET_SIZE = 4096;

    localparam int COORD_W      = 16;
    localparam int THR_W        = 16;
    localparam int BOX_INDEX_W  = 12;
    localparam int AREA_W       = 34;
    localparam int SPAN_W       = 17;
    localparam int INTER_W      = 32;
    localparam int UNI_W        = 36;
    localparam int UNI_POS_W    = 34;
    localparam int PROD_W       = THR_W + UNI_POS_W;
    localparam int FRAC_W       = 16;

    localparam int KEPT_ADDR_W  = $clog2(MAX_KEPT);
    localparam int KEPT_CNT_W   = $clog2(MAX_KEPT + 1);
    localparam int SET_POS_W    = $clog2(MAX_SET_SIZE);

    localparam logic [THR_W-1:0] THR_RESET = 16'd29491;

    typedef struct packed {
        logic signed [COORD_W-1:0] left;
        logic signed [COORD_W-1:0] top;
        logic signed [COORD_W-1:0] right;
        logic signed [COORD_W-1:0] bottom;
        logic signed [AREA_W-1:0]  area;
    } gibs_entry_t;

    localparam int ENTRY_W = $bits(gibs_entry_t);

    typedef struct packed {
        logic                   load;
        logic                   issue;
        logic [KEPT_ADDR_W-1:0] rd_addr;
        logic                   write;
        logic [KEPT_ADDR_W-1:0] wr_addr;
    } gibs_cmd_t;

    typedef struct packed {
        logic pipe_empty;
        logic suppressed;
    } gibs_status_t;

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_SCAN  = 4'b0010,
        ST_DRAIN = 4'b0100,
        ST_DONE  = 4'b1000
    } gibs_state_t;

endpackage

/* hdl/gibs_ram.sv */
// ---------------------------------------------------------------------------
// gibs_ram
// generic simple dual port ram, one write and one registered read port
// ---------------------------------------------------------------------------
module gibs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

/* hdl/gibs_dpath.sv */
// ---------------------------------------------------------------------------
// gibs_dpath
// box registers, kept box store and five stage iou compare pipeline
// ---------------------------------------------------------------------------
module gibs_dpath (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  gibs_pkg::gibs_cmd_t                     cmd,
    input  logic                                    cfg_wr_en,
    input  logic [gibs_pkg::THR_W-1:0]              cfg_wr_data,
    input  logic signed [gibs_pkg::COORD_W-1:0]     left_edge,
    input  logic signed [gibs_pkg::COORD_W-1:0]     top_edge,
    input  logic signed [gibs_pkg::COORD_W-1:0]     right_edge,
    input  logic signed [gibs_pkg::COORD_W-1:0]     bottom_edge,
    output gibs_pkg::gibs_status_t                  status
);

    import gibs_pkg::*;

    logic [THR_W-1:0]          thr_reg;
    logic signed [COORD_W-1:0] box_l_reg;
    logic signed [COORD_W-1:0] box_t_reg;
    logic signed [COORD_W-1:0] box_r_reg;
    logic signed [COORD_W-1:0] box_b_reg;
    logic signed [AREA_W-1:0]  area_reg;
    logic signed [AREA_W-1:0]  area_next;
    logic signed [SPAN_W-1:0]  dx;
    logic signed [SPAN_W-1:0]  dy;

    gibs_entry_t               wr_entry;
    gibs_entry_t               rd_entry;
    logic [ENTRY_W-1:0]        rd_word;

    logic                      v1_reg;
    logic                      v2_reg;
    logic                      v3_reg;
    logic                      v4_reg;
    logic                      v5_reg;

    logic signed [COORD_W-1:0] min_r;
    logic signed [COORD_W-1:0] max_l;
    logic signed [COORD_W-1:0] min_b;
    logic signed [COORD_W-1:0] max_t;
    logic signed [SPAN_W-1:0]  w_full;
    logic signed [SPAN_W-1:0]  h_full;
    logic [COORD_W-1:0]        w_next;
    logic [COORD_W-1:0]        h_next;

    logic [COORD_W-1:0]        w_reg;
    logic [COORD_W-1:0]        h_reg;
    logic signed [AREA_W-1:0]  s2_area_reg;
    logic [INTER_W-1:0]        inter_reg;
    logic signed [AREA_W-1:0]  s3_area_reg;
    logic signed [UNI_W-1:0]   uni_next;
    logic signed [UNI_W-1:0]   uni_reg;
    logic [INTER_W-1:0]        s4_inter_reg;
    logic [PROD_W-1:0]         prod_reg;
    logic [INTER_W-1:0]        s5_inter_reg;
    logic                      s5_pos_reg;
    logic                      s5_zero_reg;
    logic [PROD_W-1:0]         lhs;
    logic                      sup;
    logic                      suppress_reg;

    // threshold register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg <= THR_RESET;
        end
        else if (cfg_wr_en)
        begin
            thr_reg <= cfg_wr_data;
        end
    end

    // current box and its signed area
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            box_l_reg <= left_edge;
            box_t_reg <= top_edge;
            box_r_reg <= right_edge;
            box_b_reg <= bottom_edge;
        end
        area_reg <= area_next;
    end

    assign dx        = SPAN_W'(box_r_reg) - SPAN_W'(box_l_reg);
    assign dy        = SPAN_W'(box_b_reg) - SPAN_W'(box_t_reg);
    assign area_next = AREA_W'(dx * dy);

    // kept box store
    assign wr_entry.left   = box_l_reg;
    assign wr_entry.top    = box_t_reg;
    assign wr_entry.right  = box_r_reg;
    assign wr_entry.bottom = box_b_reg;
    assign wr_entry.area   = area_reg;

    gibs_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (MAX_KEPT)
    ) u_store (
        .clk     (clk),
        .wr_en   (cmd.write),
        .wr_addr (cmd.wr_addr),
        .wr_data (wr_entry),
        .rd_en   (cmd.issue),
        .rd_addr (cmd.rd_addr),
        .rd_data (rd_word)
    );

    assign rd_entry = gibs_entry_t'(rd_word);

    // stage 2: clamped overlap width and height
    assign min_r  = (box_r_reg < rd_entry.right)  ? box_r_reg : rd_entry.right;
    assign max_l  = (box_l_reg > rd_entry.left)   ? box_l_reg : rd_entry.left;
    assign min_b  = (box_b_reg < rd_entry.bottom) ? box_b_reg : rd_entry.bottom;
    assign max_t  = (box_t_reg > rd_entry.top)    ? box_t_reg : rd_entry.top;
    assign w_full = SPAN_W'(min_r) - SPAN_W'(max_l);
    assign h_full = SPAN_W'(min_b) - SPAN_W'(max_t);
    assign w_next = w_full[SPAN_W-1] ? '0 : w_full[COORD_W-1:0];
    assign h_next = h_full[SPAN_W-1] ? '0 : h_full[COORD_W-1:0];

    // stage 4: union
    assign uni_next = UNI_W'(area_reg) + UNI_W'(s3_area_reg)
                    - signed'(UNI_W'(inter_reg));

    // compare stage
    assign lhs = PROD_W'({s5_inter_reg, {FRAC_W{1'b0}}});
    assign sup = s5_pos_reg ? (lhs > prod_reg) : (s5_zero_reg && (s5_inter_reg != '0));

    always_ff @(posedge clk)
    begin
        w_reg        <= w_next;
        h_reg        <= h_next;
        s2_area_reg  <= rd_entry.area;
        inter_reg    <= INTER_W'(w_reg) * INTER_W'(h_reg);
        s3_area_reg  <= s2_area_reg;
        uni_reg      <= uni_next;
        s4_inter_reg <= inter_reg;
        prod_reg     <= PROD_W'(thr_reg) * PROD_W'(uni_reg[UNI_POS_W-1:0]);
        s5_inter_reg <= s4_inter_reg;
        s5_pos_reg   <= !uni_reg[UNI_W-1] && (uni_reg != '0);
        s5_zero_reg  <= (uni_reg == '0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg       <= 1'b0;
            v2_reg       <= 1'b0;
            v3_reg       <= 1'b0;
            v4_reg       <= 1'b0;
            v5_reg       <= 1'b0;
            suppress_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= cmd.issue;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
            if (cmd.load)
            begin
                suppress_reg <= 1'b0;
            end
            else if (v5_reg && sup)
            begin
                suppress_reg <= 1'b1;
            end
        end
    end

    assign status.pipe_empty = !(v1_reg || v2_reg || v3_reg || v4_reg || v5_reg);
    assign status.suppressed = suppress_reg;

endmodule

/* hdl/gibs_ctrl.sv */
// ---------------------------------------------------------------------------
// gibs_ctrl
// sequencer: kept count, set position, store scan and result registers
// ---------------------------------------------------------------------------
`include "greedy_iou_box_suppressor_core_assert.svh"

module gibs_ctrl (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    input  logic                               start_of_set,
    input  gibs_pkg::gibs_status_t             status,
    output gibs_pkg::gibs_cmd_t                cmd,
    output logic                               busy,
    output logic                               done,
    output logic                               keep,
    output logic [gibs_pkg::BOX_INDEX_W-1:0]   box_index,
    output logic                               store_full
);

    import gibs_pkg::*;

    gibs_state_t            state_reg;
    gibs_state_t            state_next;
    logic [KEPT_ADDR_W-1:0] scan_reg;
    logic [KEPT_ADDR_W-1:0] scan_next;
    logic [KEPT_CNT_W-1:0]  count_reg;
    logic [KEPT_CNT_W-1:0]  count_next;
    logic [SET_POS_W-1:0]   pos_reg;
    logic [SET_POS_W-1:0]   pos_next;
    logic [SET_POS_W-1:0]   index_reg;
    logic [SET_POS_W-1:0]   index_next;
    logic                   done_reg;
    logic                   done_next;
    logic                   keep_reg;
    logic                   keep_next;
    logic                   full_reg;
    logic                   full_next;
    logic [KEPT_CNT_W-1:0]  cur_count;
    logic [SET_POS_W-1:0]   cur_pos;

    assign cur_count = start_of_set ? '0 : count_reg;
    assign cur_pos   = start_of_set ? '0 : pos_reg;

    always_comb
    begin
        state_next = state_reg;
        scan_next  = scan_reg;
        count_next = count_reg;
        pos_next   = pos_reg;
        index_next = index_reg;
        done_next  = 1'b0;
        keep_next  = keep_reg;
        full_next  = full_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    cmd.load   = 1'b1;
                    count_next = cur_count;
                    index_next = cur_pos;
                    scan_next  = '0;
                    if (cur_pos != SET_POS_W'(MAX_SET_SIZE - 1))
                    begin
                        pos_next = cur_pos + SET_POS_W'(1);
                    end
                    else
                    begin
                        pos_next = cur_pos;
                    end
                    state_next = (cur_count == '0) ? ST_DRAIN : ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                cmd.issue   = 1'b1;
                cmd.rd_addr = scan_reg;
                scan_next   = scan_reg + KEPT_ADDR_W'(1);
                if (KEPT_CNT_W'(scan_reg) == count_reg - KEPT_CNT_W'(1))
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (status.pipe_empty)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                done_next = 1'b1;
                keep_next = !status.suppressed;
                full_next = 1'b0;
                if (!status.suppressed)
                begin
                    if (count_reg < KEPT_CNT_W'(MAX_KEPT))
                    begin
                        cmd.write   = 1'b1;
                        cmd.wr_addr = count_reg[KEPT_ADDR_W-1:0];
                        count_next  = count_reg + KEPT_CNT_W'(1);
                    end
                    else
                    begin
                        full_next = 1'b1;
                    end
                end
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            scan_reg  <= '0;
            count_reg <= '0;
            pos_reg   <= '0;
            index_reg <= '0;
            done_reg  <= 1'b0;
            keep_reg  <= 1'b0;
            full_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            scan_reg  <= scan_next;
            count_reg <= count_next;
            pos_reg   <= pos_next;
            index_reg <= index_next;
            done_reg  <= done_next;
            keep_reg  <= keep_next;
            full_reg  <= full_next;
        end
    end

    assign busy       = (state_reg != ST_IDLE);
    assign done       = done_reg;
    assign keep       = keep_reg;
    assign store_full = full_reg;
    assign box_index  = BOX_INDEX_W'(index_reg);

    `GIBS_ASSERT_NEXT(a_accept_busy, clk, rst_n, start && !busy, busy)
    `GIBS_ASSERT_NEXT(a_done_ends_item, clk, rst_n, state_reg == ST_DONE, done_reg && !busy)
    `GIBS_ASSERT(a_full_only_kept, clk, rst_n, !full_reg || keep_reg)
    `GIBS_ASSERT(a_count_bound, clk, rst_n, count_reg <= KEPT_CNT_W'(MAX_KEPT))
    `GIBS_ASSERT(a_scan_in_list, clk, rst_n, !cmd.issue || (KEPT_CNT_W'(cmd.rd_addr) < count_reg))

endmodule

/* hdl/greedy_iou_box_suppressor_core.sv */
// ---------------------------------------------------------------------------
// greedy_iou_box_suppressor_core
// greedy non-maximum suppression over score-sorted boxes by iou threshold
// ---------------------------------------------------------------------------
// channel   handshake          payload
// box in    start / busy       start_of_set, left/top/right/bottom_edge
// result    done (strobe)      keep, box_index, store_full
// config    cfg_wr_en          cfg_wr_data (iou_threshold)
//
// a box is compared with every kept box before done; with an empty list the scan is skipped
// one kept box per cycle is read from the store into a five stage compare pipe
// busy is high from accept until the result beat; start is ignored meanwhile
// the result beat lasts one cycle and cannot be stalled
// reset clears the counters, flags and threshold, not the store; the store needs no clearing pass
// ---------------------------------------------------------------------------
module greedy_iou_box_suppressor_core (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  start,
    output logic                                  busy,
    input  logic                                  start_of_set,
    input  logic signed [gibs_pkg::COORD_W-1:0]   left_edge,
    input  logic signed [gibs_pkg::COORD_W-1:0]   top_edge,
    input  logic signed [gibs_pkg::COORD_W-1:0]   right_edge,
    input  logic signed [gibs_pkg::COORD_W-1:0]   bottom_edge,
    output logic                                  done,
    output logic                                  keep,
    output logic [gibs_pkg::BOX_INDEX_W-1:0]      box_index,
    output logic                                  store_full,
    input  logic                                  cfg_wr_en,
    input  logic [gibs_pkg::THR_W-1:0]            cfg_wr_data
);

    import gibs_pkg::*;

    gibs_cmd_t    cmd;
    gibs_status_t status;

    gibs_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .start_of_set (start_of_set),
        .status       (status),
        .cmd          (cmd),
        .busy         (busy),
        .done         (done),
        .keep         (keep),
        .box_index    (box_index),
        .store_full   (store_full)
    );

    gibs_dpath u_dpath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .left_edge   (left_edge),
        .top_edge    (top_edge),
        .right_edge  (right_edge),
        .bottom_edge (bottom_edge),
        .status      (status)
    );

endmodule

/* dv/greedy_iou_box_suppressor_checker.sv */
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// greedy_iou_box_suppressor_checker
// watches the box, result and threshold channels of the suppressor, keeps its
// own kept list and set counter, works out the verdict for every accepted box
// and compares each result beat field by field with the oldest verdict due
// ---------------------------------------------------------------------------
module greedy_iou_box_suppressor_checker (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  start,
    input  logic                                  busy,
    input  logic                                  start_of_set,
    input  logic signed [gibs_pkg::COORD_W-1:0]   left_edge,
    input  logic signed [gibs_pkg::COORD_W-1:0]   top_edge,
    input  logic signed [gibs_pkg::COORD_W-1:0]   right_edge,
    input  logic signed [gibs_pkg::COORD_W-1:0]   bottom_edge,
    input  logic                                  done,
    input  logic                                  keep,
    input  logic [gibs_pkg::BOX_INDEX_W-1:0]      box_index,
    input  logic                                  store_full,
    input  logic                                  cfg_wr_en,
    input  logic [gibs_pkg::THR_W-1:0]            cfg_wr_data,
    output int                                    mismatch_count,
    output int                                    verdicts_pending
);

    typedef struct packed {
        logic                              keep;
        logic [gibs_pkg::BOX_INDEX_W-1:0]  box_index;
        logic                              store_full;
    } verdict_t;

    gibs_pkg::gibs_entry_t              kept_boxes [gibs_pkg::MAX_KEPT];
    int unsigned                        kept_total;
    int unsigned                        set_pos;
    logic [gibs_pkg::THR_W-1:0]         iou_limit;
    verdict_t                           expected_verdicts [$];
    int                                 failures;

    function automatic bit is_suppressed(input gibs_pkg::gibs_entry_t kept,
                                         input int l, input int t, input int r, input int b,
                                         input longint area, input logic [15:0] thr);
        int     kl, kt, kr, kb, w, h;
        longint inter, uni;
        kl = $signed(kept.left);
        kt = $signed(kept.top);
        kr = $signed(kept.right);
        kb = $signed(kept.bottom);
        w = ((r < kr) ? r : kr) - ((l > kl) ? l : kl);
        h = ((b < kb) ? b : kb) - ((t > kt) ? t : kt);
        if (w < 0)
            w = 0;
        if (h < 0)
            h = 0;
        inter = longint'(w) * longint'(h);
        uni = area + longint'($signed(kept.area)) - inter;
        if (uni > 0)
            return (inter * 65536) > (longint'(thr) * uni);
        return (uni == 0) && (inter > 0);
    endfunction

    task automatic judge_box(input logic sos, input int l, input int t, input int r,
                             input int b);
        longint      area;
        verdict_t    v;
        int unsigned k;
        area = longint'(r - l) * longint'(b - t);
        if (sos)
        begin
            kept_total = 0;
            set_pos = 0;
        end
        v.box_index = set_pos[gibs_pkg::BOX_INDEX_W-1:0];
        if (set_pos < gibs_pkg::MAX_SET_SIZE - 1)
            set_pos++;
        v.keep = 1'b1;
        v.store_full = 1'b0;
        for (k = 0; k < kept_total; k++)
            if (is_suppressed(kept_boxes[k], l, t, r, b, area, iou_limit))
                v.keep = 1'b0;
        if (v.keep)
        begin
            if (kept_total < gibs_pkg::MAX_KEPT)
            begin
                kept_boxes[kept_total].left   = l[15:0];
                kept_boxes[kept_total].top    = t[15:0];
                kept_boxes[kept_total].right  = r[15:0];
                kept_boxes[kept_total].bottom = b[15:0];
                kept_boxes[kept_total].area   = area[gibs_pkg::AREA_W-1:0];
                kept_total++;
            end
            else
                v.store_full = 1'b1;
        end
        expected_verdicts.insert(expected_verdicts.size(), v);
    endtask

    task automatic check_result();
        verdict_t v;
        if (expected_verdicts.size() == 0)
        begin
            $error("result beat with no box pending: keep %0d box_index %0d store_full %0d",
                   keep, box_index, store_full);
            failures++;
        end
        else
        begin
            v = expected_verdicts.pop_front();
            if (keep !== v.keep)
            begin
                $error("keep: expected %0d, actual %0d", v.keep, keep);
                failures++;
            end
            if (box_index !== v.box_index)
            begin
                $error("box_index: expected %0d, actual %0d", v.box_index, box_index);
                failures++;
            end
            if (store_full !== v.store_full)
            begin
                $error("store_full: expected %0d, actual %0d", v.store_full, store_full);
                failures++;
            end
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kept_total = 0;
            set_pos = 0;
            iou_limit = gibs_pkg::THR_RESET;
            failures = 0;
            expected_verdicts.delete();
            mismatch_count <= 0;
            verdicts_pending <= 0;
        end
        else
        begin
            if (done)
                check_result();
            if (start && !busy)
                judge_box(start_of_set, left_edge, top_edge, right_edge, bottom_edge);
            if (cfg_wr_en)
                iou_limit = cfg_wr_data;
            mismatch_count <= failures;
            verdicts_pending <= expected_verdicts.size();
        end
    end

endmodule

/* dv/greedy_iou_box_suppressor_core_test.sv */
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// greedy_iou_box_suppressor_core_test
// drives boxes into the suppressor in bursts with random gaps: a directed
// pass over edge values and union corner cases, then random sets of disjoint,
// clustered and noisy boxes under several thresholds; the checker beside the
// block judges every beat
// ---------------------------------------------------------------------------
module greedy_iou_box_suppressor_core_test;

    localparam int                          WATCHDOG_LIMIT = 5000;
    localparam int                          PHASE_BOXES    = 300;
    localparam int                          SETTLE_CYCLES  = 80;
    localparam logic [gibs_pkg::THR_W-1:0]  THR_ZERO       = 16'd0;
    localparam logic [gibs_pkg::THR_W-1:0]  THR_ONE        = 16'd1;
    localparam logic [gibs_pkg::THR_W-1:0]  THR_HALF       = 16'h8000;
    localparam logic [gibs_pkg::THR_W-1:0]  THR_FULL       = 16'hFFFF;

    typedef struct packed {
        logic signed [gibs_pkg::COORD_W-1:0] l;
        logic signed [gibs_pkg::COORD_W-1:0] t;
        logic signed [gibs_pkg::COORD_W-1:0] r;
        logic signed [gibs_pkg::COORD_W-1:0] b;
    } box_t;

    logic                                  clk = 1'b0;
    logic                                  rst_n = 1'b0;
    logic                                  start = 1'b0;
    logic                                  start_of_set = 1'b0;
    logic signed [gibs_pkg::COORD_W-1:0]   left_edge = '0;
    logic signed [gibs_pkg::COORD_W-1:0]   top_edge = '0;
    logic signed [gibs_pkg::COORD_W-1:0]   right_edge = '0;
    logic signed [gibs_pkg::COORD_W-1:0]   bottom_edge = '0;
    logic                                  cfg_wr_en = 1'b0;
    logic [gibs_pkg::THR_W-1:0]            cfg_wr_data = '0;
    logic                                  busy;
    logic                                  done;
    logic                                  keep;
    logic [gibs_pkg::BOX_INDEX_W-1:0]      box_index;
    logic                                  store_full;
    int                                    mismatch_count;
    int                                    verdicts_pending;
    int                                    idle_cycles = 0;
    int                                    burst_left = 0;

    greedy_iou_box_suppressor_core dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .start_of_set (start_of_set),
        .left_edge    (left_edge),
        .top_edge     (top_edge),
        .right_edge   (right_edge),
        .bottom_edge  (bottom_edge),
        .done         (done),
        .keep         (keep),
        .box_index    (box_index),
        .store_full   (store_full),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data)
    );

    greedy_iou_box_suppressor_checker checker_i (
        .clk              (clk),
        .rst_n            (rst_n),
        .start            (start),
        .busy             (busy),
        .start_of_set     (start_of_set),
        .left_edge        (left_edge),
        .top_edge         (top_edge),
        .right_edge       (right_edge),
        .bottom_edge      (bottom_edge),
        .done             (done),
        .keep             (keep),
        .box_index        (box_index),
        .store_full       (store_full),
        .cfg_wr_en        (cfg_wr_en),
        .cfg_wr_data      (cfg_wr_data),
        .mismatch_count   (mismatch_count),
        .verdicts_pending (verdicts_pending)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        if ((start && !busy) || done)
            idle_cycles <= 0;
        else
        begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("Test completed with failures");
                $finish;
            end
        end
    end

    function automatic box_t box_of(input int l, input int t, input int r, input int b);
        box_t bx;
        bx.l = l[15:0];
        bx.t = t[15:0];
        bx.r = r[15:0];
        bx.b = b[15:0];
        return bx;
    endfunction

    function automatic box_t noise_box();
        return box_of($urandom, $urandom, $urandom, $urandom);
    endfunction

    // disjoint cells of a 16 wide grid
    function automatic box_t grid_box(input int slot);
        int x0, y0;
        x0 = -16000 + (slot % 16) * 2000 + int'($urandom_range(0, 500));
        y0 = -16000 + (slot / 16) * 2000 + int'($urandom_range(0, 500));
        return box_of(x0, y0, x0 + int'($urandom_range(0, 1400)),
                      y0 + int'($urandom_range(0, 1400)));
    endfunction

    function automatic box_t hub_box();
        int x0, y0;
        x0 = int'($urandom_range(0, 58000)) - 29000;
        y0 = int'($urandom_range(0, 58000)) - 29000;
        return box_of(x0, y0, x0 + int'($urandom_range(1, 2000)),
                      y0 + int'($urandom_range(1, 2000)));
    endfunction

    function automatic box_t jitter_box(input box_t hub, input int spread);
        return box_of(int'(hub.l) + int'($urandom_range(0, 2 * spread)) - spread,
                      int'(hub.t) + int'($urandom_range(0, 2 * spread)) - spread,
                      int'(hub.r) + int'($urandom_range(0, 2 * spread)) - spread,
                      int'(hub.b) + int'($urandom_range(0, 2 * spread)) - spread);
    endfunction

    task automatic send_box(input logic sos, input box_t bx);
        int gap;
        start <= 1'b1;
        start_of_set <= sos;
        left_edge <= bx.l;
        top_edge <= bx.t;
        right_edge <= bx.r;
        bottom_edge <= bx.b;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        if (burst_left > 0)
            burst_left--;
        else
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : int'($urandom_range(1, 20));
            burst_left = ($urandom_range(0, 4) == 0) ? int'($urandom_range(20, 60))
                                                     : int'($urandom_range(0, 8));
            if (gap > 0)
            begin
                start <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
    endtask

    task automatic drain();
        start <= 1'b0;
        @(posedge clk);
        while (verdicts_pending != 0 || busy)
            @(posedge clk);
        burst_left = 0;
    endtask

    task automatic write_threshold(input logic [gibs_pkg::THR_W-1:0] value);
        drain();
        repeat (4) @(posedge clk);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        @(posedge clk);
    endtask

    task automatic run_directed();
        send_box(1'b1, box_of(0, 0, 100, 100));
        send_box(1'b0, box_of(0, 0, 100, 100));
        send_box(1'b0, box_of(50, 0, 150, 100));
        send_box(1'b0, box_of(0, 0, 100, 120));
        send_box(1'b0, box_of(-32768, -32768, 32767, 32767));
        send_box(1'b0, box_of(32767, 32767, -32768, -32768));
        send_box(1'b0, box_of(5, 5, 5, 5));
        send_box(1'b0, box_of(10, 200, 0, 210));
        // inverted kept box, union comes out zero with no overlap
        send_box(1'b1, box_of(10, 0, 0, 10));
        send_box(1'b0, box_of(0, 0, 10, 10));
        // negative union
        send_box(1'b1, box_of(20, 0, 0, 10));
        send_box(1'b0, box_of(0, 0, 10, 10));
        send_box(1'b0, box_of(0, 0, 10, 10));
        send_box(1'b1, box_of(0, 0, 0, 0));
        send_box(1'b0, box_of(0, 0, 0, 0));
        send_box(1'b1, box_of(-32768, 0, 32767, 1));
        send_box(1'b0, box_of(-32768, 0, 32767, 1));
        send_box(1'b0, box_of(32767, 0, -32768, 1));
        send_box(1'b0, box_of(-1, -1, -1, -1));
        send_box(1'b1, box_of(32767, -32768, 32767, -32768));
    endtask

    task automatic run_random(input int count);
        int   sent;
        int   kind;
        int   len;
        int   i;
        int   hubs;
        box_t hub [4];
        box_t bx;
        sent = 0;
        while (sent < count)
        begin
            kind = $urandom_range(0, 9);
            if (kind <= 1)
            begin
                // up to 90 mostly disjoint boxes, which can overrun the kept store
                len = $urandom_range(60, 90);
                for (i = 0; i < len; i++)
                begin
                    if (i > 0 && $urandom_range(0, 7) == 0)
                        bx = jitter_box(grid_box($urandom_range(0, i - 1)), 300);
                    else
                        bx = grid_box(i);
                    send_box(i == 0, bx);
                end
            end
            else if (kind <= 7)
            begin
                len = $urandom_range(1, 40);
                hubs = $urandom_range(1, 4);
                for (i = 0; i < hubs; i++)
                    hub[i] = hub_box();
                for (i = 0; i < len; i++)
                begin
                    bx = hub[$urandom_range(0, hubs - 1)];
                    send_box(i == 0, jitter_box(bx,
                             $urandom_range(0, (int'(bx.r) - int'(bx.l)) / 3 + 1)));
                end
            end
            else if (kind == 8)
            begin
                len = $urandom_range(1, 10);
                for (i = 0; i < len; i++)
                    send_box(i == 0, noise_box());
            end
            else
            begin
                // broken sequences: set starts at random places
                len = $urandom_range(1, 10);
                hub[0] = hub_box();
                for (i = 0; i < len; i++)
                    send_box(1'($urandom_range(0, 1)),
                             $urandom_range(0, 1) ? noise_box() : jitter_box(hub[0], 200));
            end
            sent += len;
        end
    endtask

    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);
        run_directed();
        write_threshold(THR_ZERO);
        run_random(PHASE_BOXES);
        write_threshold(THR_FULL);
        run_random(PHASE_BOXES);
        write_threshold(16'($urandom_range(0, 65535)));
        run_random(PHASE_BOXES);
        write_threshold(THR_HALF);
        run_random(PHASE_BOXES);
        write_threshold(THR_ONE);
        run_random(PHASE_BOXES);
        write_threshold(gibs_pkg::THR_RESET);
        run_random(PHASE_BOXES);
        drain();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
